>>> sv/ps2rx_pkg.sv
package ps2rx_pkg;

  localparam int DATA_BITS = 8;
  localparam int TIMEOUT_W = 16;
  localparam int TIME_W    = 32;
  localparam int EDGE_CNT_W = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_KEY  = 1'd1;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd20;
  localparam logic [DATA_BITS-1:0] NO_KEY_RESET  = 8'd0;

  typedef struct packed {
    logic [1:0]           op;
    logic [DATA_BITS-1:0] data;
  } word_t;

endpackage

>>> sv/ps2_frame_receiver_fifo.sv
// PS/2 receiver with a receive byte FIFO. Each input word is either a falling
// edge of the clock of PS/2 (cmd 0, with the data sample and a millisecond
// timestamp) or a read request (cmd 1). Every input word yields exactly one
// result word, in order. One word is taken per clock cycle when the result
// side keeps out_ready high: the frame assembler is combinational over its
// registered state, and the byte FIFO does at most one push or one pop per
// word. An accepted word passes the queue register and the result register
// to out_valid. A two-entry queue between the frame assembler and the byte
// FIFO lets each side stall on its own. Write timeout_ms (index 0) and
// no_key_code (index 1) only while no word is in flight.
module ps2_frame_receiver_fifo #(
  parameter int FIFO_DEPTH = 16,
  parameter int FRAME_BITS = 11,
  localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ps2rx_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ps2rx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic                                 in_data_bit,
  input  logic [ps2rx_pkg::TIME_W-1:0]         in_time_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ps2rx_pkg::DATA_BITS-1:0]      out_read_byte,
  output logic                                 out_read_valid,
  output logic                                 out_byte_pushed,
  output logic                                 out_byte_dropped,
  output logic [CW-1:0]                        out_fifo_count
);

  logic [ps2rx_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [ps2rx_pkg::DATA_BITS-1:0] no_key_r;

  ps2rx_pkg::word_t front_word, back_word;
  logic             back_valid, back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ps2rx_pkg::TIMEOUT_RESET;
      no_key_r  <= ps2rx_pkg::NO_KEY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ps2rx_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata;
        ps2rx_pkg::CFG_NO_KEY:  no_key_r  <= cfg_wdata[ps2rx_pkg::DATA_BITS-1:0];
        default: ;
      endcase
    end
  end

  ps2rx_front #(
    .FRAME_BITS(FRAME_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_data_bit(in_data_bit),
    .in_time_ms (in_time_ms),
    .timeout_ms (timeout_r),
    .word       (front_word)
  );

  ps2rx_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_valid),
    .wr_ready(in_ready),
    .wr_word (front_word),
    .rd_valid(back_valid),
    .rd_ready(back_ready),
    .rd_word (back_word)
  );

  ps2rx_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (back_valid),
    .q_ready         (back_ready),
    .q_word          (back_word),
    .no_key_code     (no_key_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_byte   (out_read_byte),
    .out_read_valid  (out_read_valid),
    .out_byte_pushed (out_byte_pushed),
    .out_byte_dropped(out_byte_dropped),
    .out_fifo_count  (out_fifo_count)
  );

endmodule

>>> sv/ps2rx_front.sv
module ps2rx_front #(
  parameter int FRAME_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_cmd,
  input  logic                                in_data_bit,
  input  logic [ps2rx_pkg::TIME_W-1:0]        in_time_ms,
  input  logic [ps2rx_pkg::TIMEOUT_W-1:0]     timeout_ms,
  output ps2rx_pkg::word_t                    word
);

  logic [ps2rx_pkg::TIME_W-1:0]     last_time_r, last_time_nxt;
  logic [ps2rx_pkg::DATA_BITS-1:0]  shift_r, shift_nxt;
  logic [ps2rx_pkg::EDGE_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ps2rx_pkg::TIME_W-1:0]     elapsed;
  logic                             timed_out;
  logic [ps2rx_pkg::EDGE_CNT_W-1:0] cnt_base, cnt_new, cnt_m1;
  logic [ps2rx_pkg::DATA_BITS-1:0]  shift_base, shift_new;
  logic [2:0]                       bit_idx;

  always_comb begin
    elapsed    = in_time_ms - last_time_r;
    timed_out  = elapsed > ps2rx_pkg::TIME_W'(timeout_ms);
    cnt_base   = timed_out ? '0 : cnt_r;
    shift_base = timed_out ? '0 : shift_r;
    cnt_m1     = cnt_base - 4'd1;
    bit_idx    = cnt_m1[2:0];
    shift_new  = shift_base;
    if ((cnt_base >= 4'd1) &&
        (cnt_base <= ps2rx_pkg::EDGE_CNT_W'(ps2rx_pkg::DATA_BITS))) begin
      shift_new[bit_idx] = shift_base[bit_idx] | in_data_bit;
    end
    cnt_new = cnt_base + 4'd1;

    last_time_nxt = last_time_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    word.op       = ps2rx_pkg::OP_READ;
    word.data     = '0;
    if (in_cmd == ps2rx_pkg::CMD_EDGE) begin
      last_time_nxt = in_time_ms;
      if (cnt_new == ps2rx_pkg::EDGE_CNT_W'(FRAME_BITS)) begin
        word.op   = ps2rx_pkg::OP_PUSH;
        word.data = shift_new;
        shift_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        word.op   = ps2rx_pkg::OP_EDGE;
        shift_nxt = shift_new;
        cnt_nxt   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      shift_r     <= '0;
      cnt_r       <= '0;
    end else if (in_valid && in_ready) begin
      last_time_r <= last_time_nxt;
      shift_r     <= shift_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

>>> sv/ps2rx_queue.sv
module ps2rx_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  ps2rx_pkg::word_t wr_word,
  output logic             rd_valid,
  input  logic             rd_ready,
  output ps2rx_pkg::word_t rd_word
);

  ps2rx_pkg::word_t q_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_word  = q_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

>>> sv/ps2rx_back.sv
module ps2rx_back #(
  parameter int FIFO_DEPTH = 16,
  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  ps2rx_pkg::word_t                  q_word,
  input  logic [ps2rx_pkg::DATA_BITS-1:0]   no_key_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ps2rx_pkg::DATA_BITS-1:0]   out_read_byte,
  output logic                              out_read_valid,
  output logic                              out_byte_pushed,
  output logic                              out_byte_dropped,
  output logic [CW-1:0]                     out_fifo_count
);

  logic [ps2rx_pkg::DATA_BITS-1:0] mem [FIFO_DEPTH];

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          out_valid_r;
  logic [ps2rx_pkg::DATA_BITS-1:0] byte_r;
  logic          rvalid_r, pushed_r, dropped_r;
  logic [CW-1:0] count_r;

  logic take, empty, full, do_push, do_pop;

  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;
  assign empty   = (len_r == '0);
  assign full    = (len_r == CW'(FIFO_DEPTH));
  assign do_push = take && (q_word.op == ps2rx_pkg::OP_PUSH) && !full;
  assign do_pop  = take && (q_word.op == ps2rx_pkg::OP_READ) && !empty;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    len_nxt  = len_r;
    if (do_push) begin
      head_nxt = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      len_nxt  = len_r + 1'b1;
    end
    if (do_pop) begin
      tail_nxt = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      len_nxt  = len_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      len_r  <= len_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[head_r] <= q_word.data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rvalid_r  <= do_pop;
      pushed_r  <= do_push;
      dropped_r <= (q_word.op == ps2rx_pkg::OP_PUSH) && full;
      count_r   <= len_nxt;
      if (q_word.op == ps2rx_pkg::OP_READ) begin
        byte_r <= empty ? no_key_code : mem[tail_r];
      end else begin
        byte_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_byte    = byte_r;
  assign out_read_valid   = rvalid_r;
  assign out_byte_pushed  = pushed_r;
  assign out_byte_dropped = dropped_r;
  assign out_fifo_count   = count_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FIFO_DEPTH = 16;
  localparam int FRAME_BITS = 11;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_WORDS = 1300;
  localparam int N_PHASES = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [ps2rx_pkg::DATA_BITS-1:0] read_byte;
    logic                            read_valid;
    logic                            pushed;
    logic                            dropped;
    logic [CNT_W-1:0]                count;
  } rx_result_t;

  typedef struct packed {
    logic        cmd;
    logic        data_b;
    logic [31:0] t_ms;
    logic        typed;
    rx_result_t  want;
  } stim_row_t;

  localparam rx_result_t NONE = '0;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [ps2rx_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ps2rx_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_cmd;
  logic                             in_data_bit;
  logic [ps2rx_pkg::TIME_W-1:0]     in_time_ms;
  logic                             out_valid;
  logic                             out_ready;
  logic [ps2rx_pkg::DATA_BITS-1:0]  out_read_byte;
  logic                             out_read_valid;
  logic                             out_byte_pushed;
  logic                             out_byte_dropped;
  logic [CNT_W-1:0]                 out_fifo_count;

  // predictor state and its copy of the registers
  logic [ps2rx_pkg::TIMEOUT_W-1:0] timeout_reg = ps2rx_pkg::TIMEOUT_RESET;
  logic [ps2rx_pkg::DATA_BITS-1:0] no_key_reg = ps2rx_pkg::NO_KEY_RESET;
  logic [31:0]                     last_edge_ms = '0;
  logic [ps2rx_pkg::DATA_BITS-1:0] shift_reg = '0;
  int                              edge_idx = 0;
  logic [ps2rx_pkg::DATA_BITS-1:0] fifo_mem [FIFO_DEPTH];
  int                              fifo_len = 0;
  int                              fifo_wr = 0;

  rx_result_t pending_results [$];
  logic       cur_typed = 1'b0;
  rx_result_t cur_want = '0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  logic [31:0] now_ms = '0;

  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_pushed = 0;
  int n_dropped = 0;
  int n_popped = 0;
  int n_empty = 0;
  int n_timeouts = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  stim_row_t dir_tab [21] = '{
    '{ps2rx_pkg::CMD_READ, 1'b1, 32'hFFFF_FFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{ps2rx_pkg::CMD_EDGE, 1'b0, 32'd1,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd2,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd3,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd4,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd5,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd6,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd7,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd8,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd9,  1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b0, 32'd10, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'd11, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 5'd1}},
    '{ps2rx_pkg::CMD_READ, 1'b0, 32'd0,  1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 5'd0}},
    '{ps2rx_pkg::CMD_READ, 1'b0, 32'd0,  1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'hFFFF_FFF0, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b0, 32'hFFFF_FFFF, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'h0000_0004, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'h0000_0100, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b0, 32'h0000_0100, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'h0000_0114, 1'b0, NONE},
    '{ps2rx_pkg::CMD_EDGE, 1'b1, 32'h0000_0129, 1'b0, NONE}
  };

  ps2_frame_receiver_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .FRAME_BITS(FRAME_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_bit     (in_data_bit),
    .in_time_ms      (in_time_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_byte   (out_read_byte),
    .out_read_valid  (out_read_valid),
    .out_byte_pushed (out_byte_pushed),
    .out_byte_dropped(out_byte_dropped),
    .out_fifo_count  (out_fifo_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rx_result_t predict_word(input logic cmd, input logic data_b,
                                              input logic [31:0] t_ms);
    rx_result_t r;
    int tail;
    logic [31:0] elapsed;
    r = '0;
    if (cmd == ps2rx_pkg::CMD_READ) begin
      if (fifo_len == 0) begin
        r.read_byte = no_key_reg;
        n_empty++;
      end else begin
        tail = (fifo_wr + FIFO_DEPTH - fifo_len) % FIFO_DEPTH;
        r.read_byte = fifo_mem[tail];
        r.read_valid = 1'b1;
        fifo_len--;
        n_popped++;
      end
    end else begin
      elapsed = t_ms - last_edge_ms;
      if (elapsed > {16'd0, timeout_reg}) begin
        if (edge_idx != 0) n_timeouts++;
        shift_reg = '0;
        edge_idx = 0;
      end
      last_edge_ms = t_ms;
      if (edge_idx >= 1 && edge_idx <= ps2rx_pkg::DATA_BITS) shift_reg[edge_idx-1] = data_b;
      edge_idx++;
      if (edge_idx == FRAME_BITS) begin
        if (fifo_len < FIFO_DEPTH) begin
          fifo_mem[fifo_wr] = shift_reg;
          fifo_wr = (fifo_wr + 1) % FIFO_DEPTH;
          fifo_len++;
          r.pushed = 1'b1;
          n_pushed++;
        end else begin
          r.dropped = 1'b1;
          n_dropped++;
        end
        shift_reg = '0;
        edge_idx = 0;
      end
    end
    r.count = CNT_W'(fifo_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("mismatch at word %0d, %s: got 0x%0h, want 0x%0h", n_checked, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    rx_result_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid && in_ready) begin
        want = predict_word(in_cmd, in_data_bit, in_time_ms);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_read_byte), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_read_byte !== want.read_byte)
            report_mismatch("read_byte", 32'(out_read_byte), 32'(want.read_byte));
          if (out_read_valid !== want.read_valid)
            report_mismatch("read_valid", 32'(out_read_valid), 32'(want.read_valid));
          if (out_byte_pushed !== want.pushed)
            report_mismatch("byte_pushed", 32'(out_byte_pushed), 32'(want.pushed));
          if (out_byte_dropped !== want.dropped)
            report_mismatch("byte_dropped", 32'(out_byte_dropped), 32'(want.dropped));
          if (out_fifo_count !== want.count)
            report_mismatch("fifo_count", 32'(out_fifo_count), 32'(want.count));
          n_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 19);
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with %0d words outstanding", STALL_LIMIT,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_word(input logic cmd, input logic data_b, input logic [31:0] t_ms,
                           input logic typed, input rx_result_t want);
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (!calm && $urandom_range(99) < 19);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_data_bit <= data_b;
    in_time_ms  <= t_ms;
    cur_typed   <= typed;
    cur_want    <= want;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [ps2rx_pkg::TIMEOUT_W-1:0] tmo,
                            input logic [ps2rx_pkg::DATA_BITS-1:0] nk);
    timeout_reg = tmo;
    no_key_reg  = nk;
    n_settings++;
    cfg_we    <= 1'b1;
    cfg_addr  <= ps2rx_pkg::CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_addr  <= ps2rx_pkg::CFG_NO_KEY;
    cfg_wdata <= ps2rx_pkg::CFG_DATA_W'(nk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] short_gap();
    return $urandom_range(0, timeout_reg);
  endfunction

  function automatic logic [31:0] long_gap();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'(timeout_reg) + 32'd1 + $urandom_range(0, 500);
  endfunction

  task automatic send_frame(input bit broken);
    int cut;
    int k;
    cut = broken ? $urandom_range(1, FRAME_BITS - 1) : FRAME_BITS;
    for (k = 0; k < FRAME_BITS; k++) begin
      if (k == cut) now_ms = now_ms + long_gap();
      else if (k == 0) now_ms = now_ms + ($urandom_range(1) ? long_gap() : short_gap());
      else now_ms = now_ms + short_gap();
      send_word(ps2rx_pkg::CMD_EDGE, 1'($urandom_range(1)), now_ms, 1'b0, NONE);
    end
  endtask

  initial begin : stimulus
    int p;
    int start;
    int pick;
    int read_pct;
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    foreach (fifo_mem[i]) fifo_mem[i] = '0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = ps2rx_pkg::CFG_TIMEOUT;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_cmd      = ps2rx_pkg::CMD_EDGE;
    in_data_bit = 1'b0;
    in_time_ms  = '0;
    out_ready   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].data_b, dir_tab[i].t_ms, dir_tab[i].typed,
                dir_tab[i].want);
    drain_pause();

    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_config(16'd20, 8'h00);
        1: set_config(16'd0, 8'hFF);
        2: set_config(16'hFFFF, 8'h5A);
        3: set_config(16'd1, 8'($urandom_range(255)));
        4: set_config(16'($urandom_range(2, 2000)), 8'($urandom_range(255)));
        default: set_config(16'($urandom), 8'($urandom));
      endcase
      calm = (p == 3);
      now_ms = $urandom;
      read_pct = (p % 2 == 0) ? 4 : 50;
      start = n_sent;
      while (n_sent - start < RAND_WORDS / N_PHASES) begin
        if (p == 1 && !held && n_sent - start > RAND_WORDS / N_PHASES / 3) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 2 && !paused && n_sent - start > RAND_WORDS / N_PHASES / 2) begin
          drain_pause();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < read_pct) begin
          send_word(ps2rx_pkg::CMD_READ, 1'($urandom_range(1)), $urandom, 1'b0, NONE);
        end else if (pick < read_pct + 8) begin
          now_ms = now_ms + ($urandom_range(1) ? short_gap() : long_gap());
          send_word(ps2rx_pkg::CMD_EDGE, 1'($urandom_range(1)), now_ms, 1'b0, NONE);
        end else begin
          send_frame($urandom_range(99) < 15);
        end
      end
      drain_pause();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d words over %0d register settings: %0d bytes stored, %0d dropped",
             n_checked, n_settings, n_pushed, n_dropped);
    $display("%0d bytes read back, %0d reads of an empty fifo, %0d partial frames timed out",
             n_popped, n_empty, n_timeouts);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ps2rx_pkg.sv
sv/ps2rx_front.sv
sv/ps2rx_queue.sv
sv/ps2rx_back.sv
sv/ps2_frame_receiver_fifo.sv
verif/tb_top.sv
